// ----- design/qse_pkg.sv -----
// shared types for the quicksort engine
// holds the data width, the cell word, the cell control struct and the state enum; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qse_pkg;

  localparam int unsigned DataW = 32;

  // one element slot of the sorting chain
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] value;
  } word_t;

  // per-cycle control shared by all cells
  typedef struct packed {
    logic shift;  // move every held word one cell toward the head
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ----- design/qse_cell.sv -----
// insertion cell: keeps the smaller word, hands the larger on; on shift takes
// the right-hand held word; depends on qse_pkg for the word and control types
`timescale 1ns / 1ps
`default_nettype none

module qse_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire qse_pkg::cell_ctrl_t ctrl_i,
  input  wire qse_pkg::word_t      left_pass_i,
  input  wire qse_pkg::word_t      right_held_i,
  output qse_pkg::word_t           held_o,
  output qse_pkg::word_t           pass_o
);

  qse_pkg::word_t held_q, held_d;
  qse_pkg::word_t pass_q, pass_d;
  logic           take_left;

  // an empty cell counts as larger than anything
  assign take_left = left_pass_i.valid &&
                     (!held_q.valid || ($signed(left_pass_i.value) < $signed(held_q.value)));

  always_comb begin
    held_d = held_q;
    pass_d = left_pass_i;
    if (ctrl_i.shift) begin
      held_d = right_held_i;
      pass_d = '0;
    end else if (take_left) begin
      held_d = left_pass_i;
      pass_d = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

// ----- design/quicksort_engine.sv -----
// Sorter for data sets of up to ELEMENTS signed 32-bit words. Words are taken
// one per cycle while loading; words beyond ELEMENTS are dropped. After the
// word marked last, the input stalls while the chain of insertion cells
// settles, then the sorted words leave one per cycle in ascending order
// unless the output stalls, the final one marked; the input stays stalled
// until the final word has left. The settle time is set by the length of
// the cell chain that each word must be able to ripple through.
// depends on qse_pkg and qse_cell
`timescale 1ns / 1ps
`default_nettype none

module quicksort_engine #(
  parameter int unsigned ELEMENTS = 64
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire signed [qse_pkg::DataW-1:0] value_i,
  input  wire                             is_last_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic signed [qse_pkg::DataW-1:0] sorted_value_o,
  output logic                            last_out_o
);

  localparam int unsigned CntW = $clog2(ELEMENTS + 1);

  qse_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     settle_q, settle_d;
  logic                in_acc, out_acc, room;
  qse_pkg::word_t      in_word;
  qse_pkg::cell_ctrl_t ctrl;
  qse_pkg::word_t      held [ELEMENTS];
  qse_pkg::word_t      pass [ELEMENTS];

  assign in_stall_o = (state_q != qse_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == qse_pkg::ST_EMIT);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign room       = (count_q < CntW'(ELEMENTS));

  assign in_word.valid = in_acc && room;
  assign in_word.value = value_i;
  assign ctrl.shift    = out_acc;

  for (genvar i = 0; i < ELEMENTS; i++) begin : g_cell
    qse_pkg::word_t left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = in_word;
    end else begin : g_mid
      assign left_w = pass[i-1];
    end
    if (i == ELEMENTS - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body
      assign right_w = held[i+1];
    end
    qse_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_pass_i (left_w),
      .right_held_i(right_w),
      .held_o      (held[i]),
      .pass_o      (pass[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    settle_d = settle_q;
    case (state_q)
      qse_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (room) count_d = count_q + CntW'(1);
          if (is_last_i) begin
            state_d  = qse_pkg::ST_SETTLE;
            settle_d = CntW'(ELEMENTS - 1);
          end
        end
      end
      qse_pkg::ST_SETTLE: begin
        if (settle_q == '0) state_d = qse_pkg::ST_EMIT;
        else settle_d = settle_q - CntW'(1);
      end
      qse_pkg::ST_EMIT: begin
        if (out_acc) begin
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) state_d = qse_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = qse_pkg::ST_LOAD;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= qse_pkg::ST_LOAD;
      count_q  <= '0;
      settle_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      settle_q <= settle_d;
    end
  end

  assign sorted_value_o = held[0].value;
  assign last_out_o     = (count_q == CntW'(1));

  // the head cell always holds a real word while results are offered
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> held[0].valid)
    else $error("head cell empty while emitting");

  // the chain never spills a word off its tail
  a_no_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pass[ELEMENTS-1].valid)
    else $error("word lost off the end of the chain");

  // the marked word ends the burst
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_out_o) |=> (!out_valid_o && count_q == '0))
    else $error("results continue after the last word");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ELEMENTS))
    else $error("element count beyond capacity");

endmodule

`default_nettype wire

// ----- tb/qse_sort_checker.sv -----
// scoreboard for the quicksort engine: collects each accepted data set, sorts
// its own copy and matches every sorted word leaving the block in order
// depends on qse_pkg for the word width
`timescale 1ns / 1ps
`default_nettype none

module qse_sort_checker #(
  parameter int unsigned ELEMENTS = 64
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  input  wire                             in_stall_i,
  input  wire signed [qse_pkg::DataW-1:0] value_i,
  input  wire                             is_last_i,
  input  wire                             out_valid_i,
  input  wire                             out_stall_i,
  input  wire signed [qse_pkg::DataW-1:0] sorted_value_i,
  input  wire                             last_out_i,
  output int                              pending_o,
  output int                              fail_count_o
);

  typedef struct packed {
    logic signed [qse_pkg::DataW-1:0] value;
    logic                             last;
  } sorted_word_t;

  logic signed [qse_pkg::DataW-1:0] loaded_set[$];
  sorted_word_t                     sorted_words[$];
  int                               mismatches = 0;
  int                               words_waiting = 0;

  assign pending_o    = words_waiting;
  assign fail_count_o = mismatches;

  always @(posedge clk_i) begin : track
    logic signed [qse_pkg::DataW-1:0] key;
    int                               j;
    sorted_word_t                     want;
    sorted_word_t                     got;
    if (!rst_ni) begin
      loaded_set.delete();
      sorted_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (sorted_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected sorted word: expected none, actual %0d last %0b",
                   $time, sorted_value_i, last_out_i);
        end else begin
          want = sorted_words.pop_front();
          if (sorted_value_i !== want.value) begin
            mismatches++;
            $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                     $time, want.value, sorted_value_i);
          end
          if (last_out_i !== want.last) begin
            mismatches++;
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, want.last, last_out_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // words past a full store are dropped
        if (loaded_set.size() < ELEMENTS) loaded_set.push_back(value_i);
        if (is_last_i) begin
          for (int i = 1; i < loaded_set.size(); i++) begin
            key = loaded_set[i];
            j   = i - 1;
            while (j >= 0 && loaded_set[j] > key) begin
              loaded_set[j+1] = loaded_set[j];
              j--;
            end
            loaded_set[j+1] = key;
          end
          for (int i = 0; i < loaded_set.size(); i++) begin
            got.value = loaded_set[i];
            got.last  = (i == loaded_set.size() - 1);
            sorted_words.push_back(got);
          end
          loaded_set.delete();
        end
      end
    end
    words_waiting = sorted_words.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb_quicksort_engine.sv -----
// top of the quicksort engine bench: clock, reset, data set stimulus,
// output stall pattern and an idle watchdog; prediction lives in qse_sort_checker
`timescale 1ns / 1ps
`default_nettype none

module tb_quicksort_engine;

  localparam int unsigned Elements    = 64;
  localparam int unsigned RandomWords = 450;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned DrainCycles = 3 * Elements + 64;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic signed [qse_pkg::DataW-1:0] value = '0;
  logic                             is_last = 1'b0;
  logic                             out_stall = 1'b0;
  wire                              in_stall;
  wire                              out_valid;
  wire signed [qse_pkg::DataW-1:0]  sorted_value;
  wire                              last_out;
  int                               pending;
  int                               fail_count;
  int unsigned                      burst_left = 0;
  int unsigned                      stall_mode = 0;
  int unsigned                      stall_phase = 0;

  always #5 clk = ~clk;

  quicksort_engine #(
    .ELEMENTS(Elements)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .value_i       (value),
    .is_last_i     (is_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .sorted_value_o(sorted_value),
    .last_out_o    (last_out)
  );

  qse_sort_checker #(
    .ELEMENTS(Elements)
  ) sort_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .value_i       (value),
    .is_last_i     (is_last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .sorted_value_i(sorted_value),
    .last_out_i    (last_out),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // receiver stalls in phases: none, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_phase[2];
    endcase
  end

  // sender runs in bursts; between bursts valid drops for a random gap
  task automatic send_word(input logic signed [qse_pkg::DataW-1:0] word, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    value    <= word;
    is_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic signed [qse_pkg::DataW-1:0] pick_value(input int unsigned spread);
    logic signed [qse_pkg::DataW-1:0] word;
    case (spread)
      0: word = $urandom;
      // narrow range forces duplicates
      1: word = $signed($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 4))
          0: word = 32'sh7fffffff;
          1: word = 32'sh80000000;
          2: word = '0;
          3: word = -1;
          default: word = $urandom;
        endcase
      end
    endcase
    return word;
  endfunction

  task automatic send_set(input int unsigned count, input int unsigned spread);
    for (int unsigned k = 0; k < count; k++) send_word(pick_value(spread), k == count - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned words_sent;
    int unsigned set_size;
    words_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone word, a pair of extremes, mixed extremes, equal words, an ascending and a descending run
    send_word(32'sh7fffffff, 1'b1);
    send_word(32'sh7fffffff, 1'b0);
    send_word(32'sh80000000, 1'b1);
    send_word('0, 1'b0);
    send_word(-1, 1'b0);
    send_word(32'sh80000000, 1'b0);
    send_word(1, 1'b0);
    send_word(32'sh7fffffff, 1'b0);
    send_word(-1, 1'b1);
    repeat (4) send_word(5, 1'b0);
    send_word(5, 1'b1);
    for (int i = -3; i <= 2; i++) send_word(i, i == 2);
    for (int i = 40; i >= 0; i -= 10) send_word(i, i == 0);
    wait_drained();

    while (words_sent < RandomWords) begin
      case ($urandom_range(0, 9))
        0:       set_size = $urandom_range(Elements, Elements + 8);
        1, 2:    set_size = $urandom_range(17, 40);
        default: set_size = $urandom_range(1, 16);
      endcase
      send_set(set_size, $urandom_range(0, 2));
      words_sent += (set_size < Elements) ? set_size : Elements;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("quicksort_engine test passed");
    end else begin
      $display("quicksort_engine test failed");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("quicksort_engine test failed");
    $finish;
  end

endmodule

`default_nettype wire
